[hdl/rbes_pkg.sv]
// Shared types, constants and saturation helper for the rigid body step pipeline.
package rbes_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SCALE_W   = 17;
	localparam int unsigned MASS_W    = 31;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX   = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN   = 32'sh8000_0000;
	localparam q_t ONE_Q16 = 32'sd65536;

	localparam logic [SCALE_W-1:0] TENTH_Q16      = 17'd6554;
	localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 17'd6554;
	localparam logic [SCALE_W-1:0] TIME_STEP_RST  = 17'd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAVITY    = 2'd0,
		CFG_NO_CLIP    = 2'd1,
		CFG_STEP_SCALE = 2'd2,
		CFG_TIME_STEP  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		q_t                 gravity;
		logic               no_clip;
		logic [SCALE_W-1:0] step_scale;
		logic [SCALE_W-1:0] time_step;
	} cfg_t;

	typedef struct packed {
		q_t                pos_x;
		q_t                pos_y;
		q_t                vel_x;
		q_t                vel_y;
		q_t                force_x;
		q_t                force_y;
		logic [MASS_W-1:0] body_mass;
		logic [MASS_W-1:0] inverse_mass;
		logic [MASS_W-1:0] friction_force;
		q_t                velocity_cap;
		logic              on_ground;
	} body_t;

	// Body after the velocity update, handed from the accel half to the update half.
	typedef struct packed {
		logic              static_body;
		logic              on_ground;
		q_t                pos_x;
		q_t                pos_y;
		q_t                vel_x;
		q_t                vel_y;
		logic [MASS_W-1:0] body_mass;
		logic [MASS_W-1:0] inverse_mass;
		logic [MASS_W-1:0] friction_force;
	} mid_t;

	typedef struct packed {
		q_t next_pos_x;
		q_t next_pos_y;
		q_t next_vel_x;
		q_t next_vel_y;
	} res_t;

	function automatic q_t sat32(input logic signed [63:0] v);
		if (v > 64'(Q_MAX)) begin
			return Q_MAX;
		end
		if (v < 64'(Q_MIN)) begin
			return Q_MIN;
		end
		return signed'(v[31:0]);
	endfunction

endpackage

[hdl/rbes_cfg_regs.sv]
// Configuration register file: gravity, no-clip flag and the two step scales.
module rbes_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output rbes_pkg::cfg_t                cfg
);
	import rbes_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity    <= '0;
			cfg_q.no_clip    <= 1'b0;
			cfg_q.step_scale <= STEP_SCALE_RST;
			cfg_q.time_step  <= TIME_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRAVITY:    cfg_q.gravity    <= signed'(cfg_data);
				CFG_NO_CLIP:    cfg_q.no_clip    <= cfg_data[0];
				CFG_STEP_SCALE: cfg_q.step_scale <= cfg_data[SCALE_W-1:0];
				CFG_TIME_STEP:  cfg_q.time_step  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[hdl/rbes_accel.sv]
// Stages 1-4: acceleration from force, gravity, velocity step and terminal cap.
module rbes_accel (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           body_valid,
	input  rbes_pkg::body_t body,
	input  rbes_pkg::cfg_t  cfg,
	output logic           mid_valid,
	output rbes_pkg::mid_t  mid
);
	import rbes_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	body_t b_s1, b_s2, b_s3;
	logic signed [63:0] prod_fx_s1, prod_fy_s1;
	q_t ax_s2, ay_s2;
	logic signed [49:0] prod_ax_s3, prod_ay_s3;
	mid_t mid_s4;

	q_t gravity_sel;
	logic signed [63:0] ay_sum;
	q_t dvx, dvy;
	logic signed [32:0] new_y;
	mid_t mid_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= body_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// force times inverse mass, both axes
	always_ff @(posedge clk) begin
		if (advance) begin
			b_s1       <= body;
			prod_fx_s1 <= body.force_x * $signed({1'b0, body.inverse_mass});
			prod_fy_s1 <= body.force_y * $signed({1'b0, body.inverse_mass});
		end
	end

	assign gravity_sel = cfg.no_clip ? '0 : cfg.gravity;
	assign ay_sum = 64'(signed'(prod_fy_s1[63:16])) + 64'(gravity_sel);

	always_ff @(posedge clk) begin
		if (advance) begin
			b_s2  <= b_s1;
			ax_s2 <= sat32(64'(signed'(prod_fx_s1[63:16])));
			ay_s2 <= sat32(ay_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			b_s3       <= b_s2;
			prod_ax_s3 <= ax_s2 * $signed({1'b0, cfg.step_scale});
			prod_ay_s3 <= ay_s2 * $signed({1'b0, cfg.step_scale});
		end
	end

	assign dvx   = sat32(64'(signed'(prod_ax_s3[49:16])));
	assign dvy   = sat32(64'(signed'(prod_ay_s3[49:16])));
	assign new_y = 33'(b_s3.vel_y) + 33'(dvy);

	always_comb begin
		mid_next.static_body    = (b_s3.body_mass == '0);
		mid_next.on_ground      = b_s3.on_ground;
		mid_next.pos_x          = b_s3.pos_x;
		mid_next.pos_y          = b_s3.pos_y;
		mid_next.body_mass      = b_s3.body_mass;
		mid_next.inverse_mass   = b_s3.inverse_mass;
		mid_next.friction_force = b_s3.friction_force;
		mid_next.vel_x          = b_s3.vel_x;
		mid_next.vel_y          = b_s3.vel_y;
		if (!mid_next.static_body) begin
			if (new_y > 33'(b_s3.velocity_cap)) begin
				// terminal speed: clamp y only, leave x as it was
				mid_next.vel_y = b_s3.velocity_cap;
			end else begin
				mid_next.vel_x = sat32(64'(b_s3.vel_x) + 64'(dvx));
				mid_next.vel_y = sat32(64'(new_y));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mid_s4 <= mid_next;
		end
	end

	assign mid_valid = valid_s4;
	assign mid       = mid_s4;

endmodule

[hdl/rbes_update.sv]
// Stages 5-10: position advance and horizontal friction, ground or air form.
module rbes_update (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          mid_valid,
	input  rbes_pkg::mid_t mid,
	input  rbes_pkg::cfg_t cfg,
	output logic          res_valid,
	output rbes_pkg::res_t res
);
	import rbes_pkg::*;

	typedef enum logic [1:0] {
		VX_KEEP,
		VX_ZERO,
		VX_GROUND,
		VX_AIR
	} vx_sel_t;

	typedef struct packed {
		q_t                pos_x;
		q_t                pos_y;
		q_t                vel_x;
		q_t                vel_y;
		logic [MASS_W-1:0] inverse_mass;
		vx_sel_t           sel;
	} tail_t;

	logic valid_s5, valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	mid_t m_s5;
	logic signed [49:0] prod_vx_s5, prod_vy_s5;
	logic signed [63:0] prod_mom_s5;
	logic [61:0] prod_fs_s5;
	tail_t t_s6, t_s7, t_s8, t_s9;
	q_t gdiff_s6, adiff_s6;
	logic signed [49:0] prod_g_s7, prod_a_s7;
	q_t delta_s8, vx_air_s8, vx_air_s9;
	logic signed [63:0] prod_d_s9;
	res_t res_s10;

	tail_t t_next;
	q_t dpx, dpy;
	logic signed [47:0] mom;
	logic mom_pos;
	logic [47:0] mom_mag, g_lim;
	q_t g_lim32;
	logic [45:0] fs;
	logic signed [32:0] vx_ext;
	logic [32:0] vx_mag, a_lim;
	logic signed [33:0] a_lim_s, adiff_w;
	logic slow;
	q_t vx_ground;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (advance) begin
			valid_s5  <= mid_valid;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// position steps, momentum and friction-over-mass products
	always_ff @(posedge clk) begin
		if (advance) begin
			m_s5        <= mid;
			prod_vx_s5  <= mid.vel_x * $signed({1'b0, cfg.step_scale});
			prod_vy_s5  <= mid.vel_y * $signed({1'b0, cfg.step_scale});
			prod_mom_s5 <= $signed({1'b0, mid.body_mass}) * mid.vel_x;
			prod_fs_s5  <= mid.friction_force * mid.inverse_mass;
		end
	end

	assign dpx = sat32(64'(signed'(prod_vx_s5[49:16])));
	assign dpy = sat32(64'(signed'(prod_vy_s5[49:16])));

	// ground: move momentum toward zero by at most the friction force
	assign mom     = signed'(prod_mom_s5[63:16]);
	assign mom_pos = !mom[47] && (mom != '0);
	assign mom_mag = mom[47] ? unsigned'(-mom) : unsigned'(mom);
	assign g_lim   = (mom_mag < 48'(m_s5.friction_force)) ? mom_mag
	                                                      : 48'(m_s5.friction_force);
	assign g_lim32 = signed'(g_lim[31:0]);

	// air: move velocity toward zero by at most friction times inverse mass
	assign fs      = prod_fs_s5[61:16];
	assign vx_ext  = 33'(m_s5.vel_x);
	assign vx_mag  = m_s5.vel_x[31] ? unsigned'(-vx_ext) : unsigned'(vx_ext);
	assign a_lim   = (46'(vx_mag) < fs) ? vx_mag : fs[32:0];
	assign a_lim_s = signed'({1'b0, a_lim});
	assign adiff_w = m_s5.vel_x[31] ? -a_lim_s : a_lim_s;

	assign slow = (m_s5.vel_x > -ONE_Q16) && (m_s5.vel_x < ONE_Q16);

	always_comb begin
		t_next.inverse_mass = m_s5.inverse_mass;
		t_next.vel_x        = m_s5.vel_x;
		t_next.vel_y        = m_s5.vel_y;
		if (m_s5.static_body) begin
			t_next.pos_x = m_s5.pos_x;
			t_next.pos_y = m_s5.pos_y;
			t_next.sel   = VX_KEEP;
		end else begin
			t_next.pos_x = sat32(64'(m_s5.pos_x) + 64'(dpx));
			t_next.pos_y = sat32(64'(m_s5.pos_y) + 64'(dpy));
			if (slow) begin
				t_next.sel = VX_ZERO;
			end else if (m_s5.on_ground) begin
				t_next.sel = VX_GROUND;
			end else begin
				t_next.sel = VX_AIR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s6     <= t_next;
			gdiff_s6 <= mom_pos ? -g_lim32 : g_lim32;
			adiff_s6 <= signed'(adiff_w[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s7      <= t_s6;
			prod_g_s7 <= gdiff_s6 * $signed({1'b0, TENTH_Q16});
			prod_a_s7 <= adiff_s6 * $signed({1'b0, cfg.time_step});
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s8      <= t_s7;
			delta_s8  <= sat32(64'(signed'(prod_g_s7[49:16])));
			vx_air_s8 <= sat32(64'(t_s7.vel_x) - 64'(signed'(prod_a_s7[49:16])));
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s9      <= t_s8;
			vx_air_s9 <= vx_air_s8;
			prod_d_s9 <= delta_s8 * $signed({1'b0, t_s8.inverse_mass});
		end
	end

	assign vx_ground = sat32(64'(t_s9.vel_x)
	                         + 64'(sat32(64'(signed'(prod_d_s9[63:16])))));

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s10.next_pos_x <= t_s9.pos_x;
			res_s10.next_pos_y <= t_s9.pos_y;
			res_s10.next_vel_y <= t_s9.vel_y;
			case (t_s9.sel)
				VX_KEEP:   res_s10.next_vel_x <= t_s9.vel_x;
				VX_ZERO:   res_s10.next_vel_x <= '0;
				VX_GROUND: res_s10.next_vel_x <= vx_ground;
				VX_AIR:    res_s10.next_vel_x <= vx_air_s9;
				default:   res_s10.next_vel_x <= t_s9.vel_x;
			endcase
		end
	end

	assign res_valid = valid_s10;
	assign res       = res_s10;

endmodule

[hdl/rigid_body_euler_step.sv]
// Top level of the rigid body Euler step pipeline.
// One semi-implicit Euler step for a 2D body in signed Q16.16. The block
// takes one body request per clock while body_stall is low; its ten
// stages follow the chain of dependent multiplies in the step
// (force by inverse mass, acceleration by step scale, velocity by step scale
// and by mass, friction by 0.1 or the time step, friction delta by inverse
// mass), each multiply level in a stage of its own, its saturating add after it. The
// whole pipe moves as one: it holds while a finished result waits under
// result_stall, and body_stall is high exactly then and during reset, so a
// request can still enter whenever the output register is free or being
// taken. Bodies with zero mass come out unchanged. Configuration writes
// (gravity, no_clip, step_scale, time_step) are taken every cycle and act
// at once, so change them only with the pipe empty.
module rigid_body_euler_step (
	input  logic                          clk,
	input  logic                          arst_n,
	// body request channel
	input  logic                          body_valid,
	output logic                          body_stall,
	input  rbes_pkg::q_t                  pos_x,
	input  rbes_pkg::q_t                  pos_y,
	input  rbes_pkg::q_t                  vel_x,
	input  rbes_pkg::q_t                  vel_y,
	input  rbes_pkg::q_t                  force_x,
	input  rbes_pkg::q_t                  force_y,
	input  logic [rbes_pkg::MASS_W-1:0]   body_mass,
	input  logic [rbes_pkg::MASS_W-1:0]   inverse_mass,
	input  logic [rbes_pkg::MASS_W-1:0]   friction_force,
	input  rbes_pkg::q_t                  velocity_cap,
	input  logic                          on_ground,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output rbes_pkg::q_t                  next_pos_x,
	output rbes_pkg::q_t                  next_pos_y,
	output rbes_pkg::q_t                  next_vel_x,
	output rbes_pkg::q_t                  next_vel_y,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import rbes_pkg::*;

	cfg_t  cfg;
	body_t body;
	mid_t  mid;
	res_t  res;
	logic  mid_valid;
	logic  advance;

	// Advance every stage unless a finished result is held at the output.
	assign advance    = !(result_valid && result_stall);
	assign body_stall = !arst_n || !advance;

	always_comb begin
		body.pos_x          = pos_x;
		body.pos_y          = pos_y;
		body.vel_x          = vel_x;
		body.vel_y          = vel_y;
		body.force_x        = force_x;
		body.force_y        = force_y;
		body.body_mass      = body_mass;
		body.inverse_mass   = inverse_mass;
		body.friction_force = friction_force;
		body.velocity_cap   = velocity_cap;
		body.on_ground      = on_ground;
	end

	rbes_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Velocity half: acceleration, velocity step, terminal cap.
	rbes_accel u_accel (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.body_valid (body_valid && !body_stall),
		.body       (body),
		.cfg        (cfg),
		.mid_valid  (mid_valid),
		.mid        (mid)
	);

	// Position half: move, then friction on horizontal speed.
	rbes_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.mid_valid (mid_valid),
		.mid       (mid),
		.cfg       (cfg),
		.res_valid (result_valid),
		.res       (res)
	);

	assign next_pos_x = res.next_pos_x;
	assign next_pos_y = res.next_pos_y;
	assign next_vel_x = res.next_vel_x;
	assign next_vel_y = res.next_vel_y;

endmodule

[hdl/rbes_checker.sv]
// Port-level checks on the rigid body step pipeline, bound to the top level.
module rbes_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          body_valid,
	input logic                          body_stall,
	input rbes_pkg::q_t                  pos_x,
	input rbes_pkg::q_t                  pos_y,
	input rbes_pkg::q_t                  vel_x,
	input rbes_pkg::q_t                  vel_y,
	input logic [rbes_pkg::MASS_W-1:0]   body_mass,
	input logic                          result_valid,
	input logic                          result_stall,
	input rbes_pkg::q_t                  next_pos_x,
	input rbes_pkg::q_t                  next_pos_y,
	input rbes_pkg::q_t                  next_vel_x,
	input rbes_pkg::q_t                  next_vel_y
);
	import rbes_pkg::*;

	// A held result keeps its valid and its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid
			&& $stable(next_pos_x) && $stable(next_pos_y)
			&& $stable(next_vel_x) && $stable(next_vel_y))
		else $error("held result changed");

	// Request side stalls only while the output holds a result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		body_stall == (result_valid && result_stall))
		else $error("body_stall does not track the held result");

	// A static body with a free-running pipe comes out unchanged.
	a_static: assert property (@(posedge clk) disable iff (!arst_n)
		$past(body_valid && !body_stall && (body_mass == '0), 10)
			&& !$past(body_stall, 1) && !$past(body_stall, 2) && !$past(body_stall, 3)
			&& !$past(body_stall, 4) && !$past(body_stall, 5) && !$past(body_stall, 6)
			&& !$past(body_stall, 7) && !$past(body_stall, 8) && !$past(body_stall, 9)
		|-> result_valid
			&& next_pos_x == $past(pos_x, 10) && next_pos_y == $past(pos_y, 10)
			&& next_vel_x == $past(vel_x, 10) && next_vel_y == $past(vel_y, 10))
		else $error("static body not passed through");

endmodule

bind rigid_body_euler_step rbes_checker u_rbes_checker (.*);

[bench/rigid_body_euler_step_tb.sv]
// Self-checking testbench for the rigid body Euler step pipeline.
module rigid_body_euler_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rbes_pkg::*;

	// Quiet cycles with no handshake on any channel before the run is declared hung.
	// The worst correct case is the long output hold-off plus a full pipe.
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned PHASE_ITEMS = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 body_valid;
	logic                 body_stall;
	body_t                req;
	logic                 result_valid;
	logic                 result_stall;
	q_t                   next_pos_x;
	q_t                   next_pos_y;
	q_t                   next_vel_x;
	q_t                   next_vel_y;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// Shadow copy of the configuration registers, updated on each accepted write.
	longint cur_gravity = 0;
	bit     cur_no_clip = 1'b0;
	longint cur_step    = longint'(STEP_SCALE_RST);
	longint cur_tstep   = longint'(TIME_STEP_RST);

	// Predicted next states, oldest first.
	res_t        next_state_q[$];
	int unsigned n_bodies  = 0;
	int unsigned n_results = 0;
	int unsigned n_errors  = 0;
	int unsigned n_phases  = 0;

	// Idle shaping: a quiet side never idles; hold_len asks the sink for one long hold-off.
	bit          src_quiet  = 1'b0;
	bit          sink_quiet = 1'b0;
	int unsigned hold_len   = 0;

	rigid_body_euler_step dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.body_valid    (body_valid),
		.body_stall    (body_stall),
		.pos_x         (req.pos_x),
		.pos_y         (req.pos_y),
		.vel_x         (req.vel_x),
		.vel_y         (req.vel_y),
		.force_x       (req.force_x),
		.force_y       (req.force_y),
		.body_mass     (req.body_mass),
		.inverse_mass  (req.inverse_mass),
		.friction_force(req.friction_force),
		.velocity_cap  (req.velocity_cap),
		.on_ground     (req.on_ground),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.next_pos_x    (next_pos_x),
		.next_pos_y    (next_pos_y),
		.next_vel_x    (next_vel_x),
		.next_vel_y    (next_vel_y),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point helpers for the predictor
	// ------------------------------------------------------------------

	// Clamp to the signed 32-bit range.
	function automatic longint clip_q(input longint v);
		if (v > longint'(Q_MAX)) begin
			return longint'(Q_MAX);
		end
		if (v < longint'(Q_MIN)) begin
			return longint'(Q_MIN);
		end
		return v;
	endfunction

	// Q16.16 product, exact 64-bit product floored by the arithmetic shift.
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	// Next state of one body under the current shadow configuration.
	function automatic res_t predict_step(input body_t b);
		longint px, py, vx, vy, ax, ay, new_y, cap;
		longint mass, im, fric, mom, target, delta, fs;
		res_t   r;
		px   = longint'($signed(b.pos_x));
		py   = longint'($signed(b.pos_y));
		vx   = longint'($signed(b.vel_x));
		vy   = longint'($signed(b.vel_y));
		cap  = longint'($signed(b.velocity_cap));
		mass = longint'(b.body_mass);
		im   = longint'(b.inverse_mass);
		fric = longint'(b.friction_force);
		// Static bodies skip all of this and come out as they went in.
		if (mass != 0) begin
			ax = clip_q(qmul(longint'($signed(b.force_x)), im));
			ay = qmul(longint'($signed(b.force_y)), im);
			if (!cur_no_clip) begin
				ay += cur_gravity;
			end
			ay = clip_q(ay);
			// Terminal velocity is checked on the unsaturated sum; a capped body
			// keeps its horizontal velocity untouched.
			new_y = vy + clip_q(qmul(ay, cur_step));
			if (new_y > cap) begin
				vy = cap;
			end else begin
				vx = clip_q(vx + clip_q(qmul(ax, cur_step)));
				vy = clip_q(new_y);
			end
			px = clip_q(px + clip_q(qmul(vx, cur_step)));
			py = clip_q(py + clip_q(qmul(vy, cur_step)));
			if (vx > -longint'(ONE_Q16) && vx < longint'(ONE_Q16)) begin
				vx = 0;
			end else if (b.on_ground) begin
				// Ground form: clamp momentum toward zero by the friction force.
				mom = qmul(mass, vx);
				if (mom > 0) begin
					target = mom - fric;
					if (target < 0) begin
						target = 0;
					end
				end else begin
					target = mom + fric;
					if (target > 0) begin
						target = 0;
					end
				end
				delta = clip_q(qmul(target - mom, longint'(TENTH_Q16)));
				vx    = clip_q(vx + clip_q(qmul(delta, im)));
			end else begin
				// Air form: clamp velocity toward zero, scaled by the time step.
				fs = qmul(fric, im);
				if (vx > 0) begin
					target = vx - fs;
					if (target < 0) begin
						target = 0;
					end
				end else begin
					target = vx + fs;
					if (target > 0) begin
						target = 0;
					end
				end
				vx = clip_q(vx - qmul(vx - target, cur_tstep));
			end
		end
		r.next_pos_x = px[31:0];
		r.next_pos_y = py[31:0];
		r.next_vel_x = vx[31:0];
		r.next_vel_y = vy[31:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: sample all three channels at the rising edge
	// ------------------------------------------------------------------

	task automatic check_field(input string field, input q_t want, input q_t got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
				field, want, want, got, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n) begin
			// Mirror every accepted register write into the shadow copy.
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GRAVITY:    cur_gravity = longint'($signed(cfg_data));
					CFG_NO_CLIP:    cur_no_clip = cfg_data[0];
					CFG_STEP_SCALE: cur_step    = longint'(cfg_data[SCALE_W-1:0]);
					CFG_TIME_STEP:  cur_tstep   = longint'(cfg_data[SCALE_W-1:0]);
					default: ;
				endcase
			end
			// Predict each accepted request as it enters.
			if (body_valid && !body_stall) begin
				next_state_q.push_back(predict_step(req));
				n_bodies++;
			end
			// Compare each accepted result with the oldest prediction.
			if (result_valid && !result_stall) begin
				if (next_state_q.size() == 0) begin
					$error("unexpected result: pos (%0d, %0d) vel (%0d, %0d)",
						next_pos_x, next_pos_y, next_vel_x, next_vel_y);
					n_errors++;
				end else begin
					want = next_state_q.pop_front();
					check_field("next_pos_x", want.next_pos_x, next_pos_x);
					check_field("next_pos_y", want.next_pos_y, next_pos_y);
					check_field("next_vel_x", want.next_vel_x, next_vel_x);
					check_field("next_vel_y", want.next_vel_y, next_vel_y);
					n_results++;
				end
			end
		end
	end

	// Result sink: draw a stall length per result, or take one long hold-off
	// when a test asks for it, then accept the next result.
	initial begin : result_sink
		int unsigned wait_cycles;
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			wait_cycles = sink_quiet ? 0 : $urandom_range(0, 14);
			if (hold_len > 0) begin
				wait_cycles = hold_len;
				hold_len    = 0;
			end
			if (wait_cycles > 0) begin
				result_stall = 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (body_valid && !body_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			STALL_LIMIT, next_state_q.size());
		$display("rigid_body_euler_step test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request generation and driving (all tasks start and end at a falling edge)
	// ------------------------------------------------------------------

	// Mass, inverse mass and friction come in as full words and are cut to field width.
	function automatic body_t make_body(input q_t px, input q_t py, input q_t vx, input q_t vy,
			input q_t fx, input q_t fy, input q_t m, input q_t im, input q_t fr,
			input q_t cap, input logic grounded);
		body_t b;
		b = '{px, py, vx, vy, fx, fy, MASS_W'(m), MASS_W'(im), MASS_W'(fr), cap, grounded};
		return b;
	endfunction

	function automatic q_t pick_edge();
		case ($urandom_range(0, 7))
			0:       return Q_MIN;
			1:       return Q_MAX;
			2:       return '0;
			3:       return -1;
			4:       return 1;
			5:       return ONE_Q16;
			6:       return -ONE_Q16;
			default: return q_t'($urandom);
		endcase
	endfunction

	// Mostly plausible bodies so that the friction and cap paths are reached,
	// plus full-range noise and extreme values for the saturation logic.
	function automatic body_t rand_body();
		body_t       b;
		int unsigned kind;
		kind             = $urandom_range(0, 9);
		b.pos_x          = q_t'($urandom);
		b.pos_y          = q_t'($urandom);
		b.vel_x          = q_t'($urandom);
		b.vel_y          = q_t'($urandom);
		b.force_x        = q_t'($urandom);
		b.force_y        = q_t'($urandom);
		b.body_mass      = MASS_W'($urandom);
		b.inverse_mass   = MASS_W'($urandom);
		b.friction_force = MASS_W'($urandom);
		b.velocity_cap   = q_t'($urandom);
		b.on_ground      = 1'($urandom_range(0, 1));
		if (kind >= 2 && kind <= 8) begin
			b.pos_x          = q_t'($urandom) >>> 7;
			b.pos_y          = q_t'($urandom) >>> 7;
			b.vel_x          = q_t'($urandom) >>> 11;
			b.vel_y          = q_t'($urandom) >>> 11;
			b.force_x        = q_t'($urandom) >>> 9;
			b.force_y        = q_t'($urandom) >>> 9;
			b.body_mass      = ($urandom_range(0, 9) == 0) ? '0 : MASS_W'($urandom_range(1, 1 << 20));
			b.inverse_mass   = MASS_W'($urandom_range(0, 1 << 18));
			b.friction_force = MASS_W'($urandom_range(0, 1 << 22));
			b.velocity_cap   = ($urandom_range(0, 2) == 0) ? Q_MAX : q_t'($urandom) >>> 12;
			if (kind == 8) begin
				// Hover around the slow-speed threshold.
				b.vel_x   = q_t'($urandom) >>> 15;
				b.force_x = q_t'($urandom) >>> 14;
			end
		end else if (kind == 9) begin
			b.pos_x          = pick_edge();
			b.pos_y          = pick_edge();
			b.vel_x          = pick_edge();
			b.vel_y          = pick_edge();
			b.force_x        = pick_edge();
			b.force_y        = pick_edge();
			b.body_mass      = MASS_W'(pick_edge());
			b.inverse_mass   = MASS_W'(pick_edge());
			b.friction_force = MASS_W'(pick_edge());
			b.velocity_cap   = pick_edge();
		end
		return b;
	endfunction

	// Offer one request after a random gap; keep valid high on back-to-back requests.
	task automatic send_body(input body_t b);
		int unsigned gap;
		gap = src_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			body_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req        = b;
		body_valid = 1'b1;
		do @(posedge clk); while (body_stall);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has been checked.
	task automatic drain();
		body_valid = 1'b0;
		while (next_state_q.size() != 0) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Rewrite all four registers with the pipe empty.
	task automatic set_config(input logic [31:0] grav, input logic clip_off,
			input logic [SCALE_W-1:0] ss, input logic [SCALE_W-1:0] ts);
		drain();
		put_reg(CFG_GRAVITY, grav);
		put_reg(CFG_NO_CLIP, 32'(clip_off));
		put_reg(CFG_STEP_SCALE, 32'(ss));
		put_reg(CFG_TIME_STEP, 32'(ts));
		cfg_valid = 1'b0;
		n_phases++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Directed bodies under the reset configuration: static body, both friction
	// forms in both directions, slow speed, the cap, and saturation corners.
	task automatic test_reset_defaults();
		localparam q_t ONE = ONE_Q16;
		localparam q_t M_MAX = 32'sh7FFF_FFFF;
		send_body(make_body(123456, -98765, 3*ONE, -5*ONE, 1 << 20, -(1 << 20), 0, ONE, ONE,
			Q_MIN, 1'b1));
		send_body(make_body(0, 0, 5*ONE, 0, 0, 0, ONE, ONE, ONE/2, Q_MAX, 1'b0));
		send_body(make_body(-1000, 2000, -7*ONE, ONE, ONE, 0, 2*ONE, ONE/2, 3*ONE, Q_MAX, 1'b0));
		send_body(make_body(10*ONE, 0, 4*ONE, 0, 0, 0, 2*ONE, ONE/2, ONE, Q_MAX, 1'b1));
		send_body(make_body(0, 0, -3*ONE, 0, 0, 0, ONE, ONE, 100*ONE, Q_MAX, 1'b1));
		send_body(make_body(5, 5, ONE/2, 0, 0, 0, ONE, ONE, ONE, Q_MAX, 1'b1));
		send_body(make_body(0, 0, -ONE, 0, 0, 0, ONE, ONE, 0, Q_MAX, 1'b0));
		// Cap exceeded: only vel_y changes, vel_x ignores force_x.
		send_body(make_body(0, 0, 3*ONE, 2*ONE, ONE, 100*ONE, ONE, ONE, 0, 0, 1'b0));
		// Landing exactly on the cap is not over it.
		send_body(make_body(0, 0, 2*ONE, ONE, 0, 0, ONE, ONE, 0, ONE, 1'b1));
		send_body(make_body(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, M_MAX, M_MAX, 0, Q_MAX, 1'b1));
		send_body(make_body(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, M_MAX, M_MAX, M_MAX, Q_MAX,
			1'b0));
		send_body(make_body(0, 0, ONE, 0, 0, 0, ONE, ONE, 0, Q_MIN, 1'b0));
		send_body(make_body(-1, -1, -1, -1, -1, -1, M_MAX, 1, M_MAX, -1, 1'b1));
		send_body(make_body(0, 0, -20*ONE, 0, 0, 0, M_MAX, 1, ONE, Q_MAX, 1'b1));
	endtask

	// Gravity on and off, and the register extremes.
	task automatic test_gravity_modes();
		localparam q_t ONE = ONE_Q16;
		localparam q_t M_MAX = 32'sh7FFF_FFFF;
		set_config(-32'sd642253, 1'b0, STEP_SCALE_RST, TIME_STEP_RST);
		send_body(make_body(0, 100*ONE, 2*ONE, 0, 0, 0, ONE, ONE, ONE/4, Q_MAX, 1'b0));
		send_body(make_body(0, 100*ONE, 2*ONE, -ONE, 0, 0, ONE, ONE, ONE/4, -2*ONE, 1'b0));
		set_config(-32'sd642253, 1'b1, STEP_SCALE_RST, TIME_STEP_RST);
		send_body(make_body(0, 100*ONE, 2*ONE, 0, 0, 0, ONE, ONE, ONE/4, Q_MAX, 1'b0));
		set_config(Q_MAX, 1'b0, 17'd65536, 17'd65536);
		send_body(make_body(0, 0, ONE, 0, Q_MAX, Q_MAX, ONE, M_MAX, ONE, Q_MAX, 1'b1));
		set_config(Q_MIN, 1'b0, '0, '0);
		send_body(make_body(0, 0, -5*ONE, 0, Q_MIN, Q_MIN, ONE, M_MAX, ONE, Q_MAX, 1'b0));
	endtask

	// Hold the result side off for a long stretch while requests keep coming,
	// so the pipe fills and pushes back on body_valid.
	task automatic test_output_backpressure();
		set_config(-32'sd642253, 1'b0, STEP_SCALE_RST, TIME_STEP_RST);
		src_quiet = 1'b1;
		hold_len  = HOLD_CYCLES;
		repeat (60) send_body(rand_body());
		src_quiet = 1'b0;
		drain();
	endtask

	// Pause the sender until the pipe has fully drained, then resume.
	task automatic test_sender_pause();
		repeat (40) send_body(rand_body());
		drain();
		repeat (40) send_body(rand_body());
		drain();
	endtask

	task automatic run_phase(input logic [31:0] grav, input logic clip_off,
			input logic [SCALE_W-1:0] ss, input logic [SCALE_W-1:0] ts);
		set_config(grav, clip_off, ss, ts);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// Redraw the idle pattern now and then to get stretches with no gaps.
			if (i % 50 == 0) begin
				src_quiet  = ($urandom_range(0, 3) == 0);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			send_body(rand_body());
		end
		src_quiet  = 1'b0;
		sink_quiet = 1'b0;
		drain();
	endtask

	// Random bodies across several configurations, the extremes among them.
	task automatic test_random_sweep();
		run_phase(-32'sd642253, 1'b0, STEP_SCALE_RST, TIME_STEP_RST);
		run_phase(Q_MIN, 1'b0, 17'd65536, 17'd65536);
		run_phase(Q_MAX, 1'b1, '0, '0);
		run_phase(32'sd642253, 1'b0, '1, '1);
		run_phase($urandom, 1'($urandom_range(0, 1)), SCALE_W'($urandom_range(0, 65536)),
			SCALE_W'($urandom_range(0, 65536)));
		run_phase(q_t'($urandom) >>> 8, 1'($urandom_range(0, 1)),
			SCALE_W'($urandom_range(0, 65536)), SCALE_W'($urandom_range(0, 65536)));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		arst_n     = 1'b0;
		body_valid = 1'b0;
		req        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_GRAVITY;
		cfg_data   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_gravity_modes();
		test_output_backpressure();
		test_sender_pause();
		test_random_sweep();

		// Wait out the pipe latency to catch any stray result.
		drain();
		repeat (24) @(posedge clk);

		$display("Covered %0d bodies over %0d register settings, %0d results compared.",
			n_bodies, n_phases, n_results);
		$display("Static, capped, slow, ground and air friction bodies; %0d mismatches.",
			n_errors);
		if (n_errors == 0 && next_state_q.size() == 0) begin
			$display("rigid_body_euler_step test passed");
		end else begin
			$display("rigid_body_euler_step test failed");
		end
		$finish;
	end

endmodule
